@@ rtl/core/lbbc_pkg.sv @@
// Package for the LED blink and breathe controller: beat types, codes and constants.
package lbbc_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_SET_ONOFF  = 3'd1;
  localparam logic [2:0] FUNC_SET_BRIGHT = 3'd2;
  localparam logic [2:0] FUNC_BLINK      = 3'd3;
  localparam logic [2:0] FUNC_FADE       = 3'd4;

  // Drive levels and pattern constants.
  localparam logic [7:0]  FULL_LEVEL       = 8'd255;
  localparam logic [7:0]  ZERO_LEVEL       = 8'd0;
  localparam logic [31:0] BLINK_MIN_PERIOD = 32'd200;

  // The fade step test compares 255 * (tick_count + 2) with period / 2; the
  // running product is held in 40 bits.
  localparam int          FADE_ACC_W     = 40;
  localparam int          INTERVAL_W     = 31;
  localparam logic [FADE_ACC_W-1:0] FADE_ACC_START = FADE_ACC_W'(510);
  localparam logic [FADE_ACC_W-1:0] FADE_ACC_STEP  = FADE_ACC_W'(255);

  // Pattern mode.
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_BLINK = 2'd1,
    MODE_FADE  = 2'd2
  } mode_t;

  // One command beat.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  value;
    logic [31:0] span_ms;
    logic        repeat_mode;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] duty_level;
    logic       accepted;
    logic       pattern_running;
  } res_t;

endpackage

@@ rtl/core/led_blink_breathe_controller_top.sv @@
// Top level of the LED blink and breathe controller.
//
// Each command beat (a 1 ms tick, set on/off, set brightness, blink or fade)
// is processed and yields exactly one result beat holding
// the LED drive level, whether the command succeeded and whether a pattern is
// still running. A new command is taken every cycle; results leave through an
// output register backed by a one-beat skid register, so the command side
// stalls only when both hold beats that the result side has not yet taken.
// The has_linear register is written through the cfg channel, which is always
// ready. The fade step time, period / 510 ticks, is tracked by a running
// multiple of 255 compared with period / 2, so no divider is needed.
module led_blink_breathe_controller_top
  import lbbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  // Pattern state.
  logic                  has_linear;
  mode_t                 pattern_mode,  pattern_mode_next;
  logic                  blink_phase_on, blink_phase_on_next;
  logic [7:0]            drive_level,   drive_level_next;
  logic                  ramp_falling,  ramp_falling_next;
  logic                  repeat_flag,   repeat_flag_next;
  logic [INTERVAL_W-1:0] step_interval, step_interval_next;
  logic [INTERVAL_W-1:0] tick_count,    tick_count_next;
  logic [FADE_ACC_W-1:0] fade_acc,      fade_acc_next;
  logic                  ok;

  // Output register and skid register.
  logic skid_valid;
  res_t skid;
  res_t res_new;

  logic                  accept;
  logic [31:0]           blink_period;
  logic [INTERVAL_W-1:0] tick_inc;
  logic                  step_due;

  assign cfg_ready = 1'b1;
  assign cmd_ready = !skid_valid;
  assign accept    = cmd_valid && cmd_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      has_linear <= 1'b0;
    end else if (cfg_valid) begin
      has_linear <= cfg_data;
    end
  end

  // Blink half period and tick timing.
  assign blink_period = (cmd.span_ms < BLINK_MIN_PERIOD) ? BLINK_MIN_PERIOD : cmd.span_ms;
  assign tick_inc     = tick_count + INTERVAL_W'(1);
  assign step_due     = (pattern_mode == MODE_BLINK) ? (tick_inc >= step_interval)
                                                     : (fade_acc > FADE_ACC_W'(step_interval));

  // Next pattern state for the command beat.
  always_comb begin
    pattern_mode_next   = pattern_mode;
    blink_phase_on_next = blink_phase_on;
    drive_level_next    = drive_level;
    ramp_falling_next   = ramp_falling;
    repeat_flag_next    = repeat_flag;
    step_interval_next  = step_interval;
    tick_count_next     = tick_count;
    fade_acc_next       = fade_acc;
    ok                  = 1'b0;
    case (cmd.func)
      FUNC_TICK: begin
        ok = 1'b1;
        if (pattern_mode != MODE_IDLE) begin
          if (!step_due) begin
            tick_count_next = tick_inc;
            fade_acc_next   = fade_acc + FADE_ACC_STEP;
          end else begin
            tick_count_next = '0;
            fade_acc_next   = FADE_ACC_START;
            if (pattern_mode == MODE_BLINK) begin
              // Blink toggles; a one-shot blink ends on its first off phase.
              blink_phase_on_next = !blink_phase_on;
              drive_level_next    = blink_phase_on ? ZERO_LEVEL : FULL_LEVEL;
              if (!repeat_flag && blink_phase_on) begin
                pattern_mode_next = MODE_IDLE;
              end
            end else if (!has_linear) begin
              // Linear drive withdrawn during a fade ends it where it stands.
              pattern_mode_next = MODE_IDLE;
            end else if (!ramp_falling) begin
              if (drive_level >= 8'd254) begin
                drive_level_next  = FULL_LEVEL;
                ramp_falling_next = 1'b1;
              end else begin
                drive_level_next = drive_level + 8'd1;
              end
            end else begin
              if (drive_level <= 8'd1) begin
                drive_level_next = ZERO_LEVEL;
                if (!repeat_flag) begin
                  pattern_mode_next = MODE_IDLE;
                end else begin
                  ramp_falling_next = 1'b0;
                end
              end else begin
                drive_level_next = drive_level - 8'd1;
              end
            end
          end
        end
      end
      FUNC_SET_ONOFF: begin
        ok                = 1'b1;
        pattern_mode_next = MODE_IDLE;
        drive_level_next  = (cmd.value != ZERO_LEVEL) ? FULL_LEVEL : ZERO_LEVEL;
      end
      FUNC_SET_BRIGHT: begin
        pattern_mode_next = MODE_IDLE;
        if (has_linear || cmd.value == ZERO_LEVEL || cmd.value == FULL_LEVEL) begin
          drive_level_next = cmd.value;
          ok               = 1'b1;
        end
      end
      FUNC_BLINK, FUNC_FADE: begin
        if (cmd.span_ms != 32'd0) begin
          ok               = 1'b1;
          repeat_flag_next = cmd.repeat_mode;
          tick_count_next  = '0;
          fade_acc_next    = FADE_ACC_START;
          if (cmd.func == FUNC_FADE && has_linear) begin
            // Fade keeps period / 2; the step test divides it by 255.
            pattern_mode_next  = MODE_FADE;
            drive_level_next   = ZERO_LEVEL;
            ramp_falling_next  = 1'b0;
            step_interval_next = cmd.span_ms[31:1];
          end else begin
            pattern_mode_next   = MODE_BLINK;
            blink_phase_on_next = 1'b1;
            drive_level_next    = FULL_LEVEL;
            step_interval_next  = blink_period[31:1];
          end
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Result beat built from the state after the command.
  always_comb begin
    res_new.duty_level      = drive_level_next;
    res_new.accepted        = ok;
    res_new.pattern_running = (pattern_mode_next != MODE_IDLE);
  end

  // Pattern state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode   <= MODE_IDLE;
      blink_phase_on <= 1'b0;
      drive_level    <= ZERO_LEVEL;
      ramp_falling   <= 1'b0;
      repeat_flag    <= 1'b0;
      step_interval  <= '0;
      tick_count     <= '0;
      fade_acc       <= FADE_ACC_START;
    end else if (accept) begin
      pattern_mode   <= pattern_mode_next;
      blink_phase_on <= blink_phase_on_next;
      drive_level    <= drive_level_next;
      ramp_falling   <= ramp_falling_next;
      repeat_flag    <= repeat_flag_next;
      step_interval  <= step_interval_next;
      tick_count     <= tick_count_next;
      fade_acc       <= fade_acc_next;
    end
  end

  // Output register with a one-beat skid behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_ready || !res_valid) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (res_ready || !res_valid) begin
      if (skid_valid) begin
        res <= skid;
      end else if (accept) begin
        res <= res_new;
      end
    end else if (accept) begin
      skid <= res_new;
    end
  end

endmodule
